[hw/rtl/mfi_pkg.sv]
// Shared constants, codes and helpers for the maximum-flow engine.
`timescale 1ns / 1ps
package mfi_pkg;

    localparam int MAX_NODES = 256;
    localparam int MAX_ARCS  = 2048;
    localparam int NODE_W    = 9;
    localparam int NIDX_W    = 8;
    localparam int ARC_W     = 11;
    localparam int ARCP_W    = 12;
    localparam int CAP_W     = 31;
    localparam int LVL_W     = 9;
    localparam int POP_D     = MAX_NODES + 2;
    localparam int POP_AW    = $clog2(POP_D);
    localparam int FLOW_W    = 42;
    localparam int OUT_W     = 41;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;
    localparam int CFG_AW    = 2;

    localparam logic [CAP_W-1:0] INF_LIMIT = 31'h7fffffff;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    localparam logic FUNC_ADD = 1'b0;

    localparam logic [CFG_AW-1:0] CFG_NODES  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SOURCE = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SINK   = 2'd2;

    function automatic logic [NODE_W-1:0] eff_nodes(input logic [NODE_W-1:0] v);
        logic [NODE_W-1:0] r;
        r = v;
        if (v < NODE_W'(2)) begin
            r = NODE_W'(2);
        end else if (v > NODE_W'(MAX_NODES)) begin
            r = NODE_W'(MAX_NODES);
        end
        return r;
    endfunction

    function automatic logic [NIDX_W-1:0] node_idx(input logic [NODE_W-1:0] v);
        logic [NODE_W-1:0] d;
        d = v - NODE_W'(1);
        return d[NIDX_W-1:0];
    endfunction

endpackage

[hw/rtl/mfi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/max_flow_isap_engine_core.sv]
// Top level of the ISAP maximum-flow engine with edge store and solve sequencer.
//
// Channel   Direction  Payload
// s_        in         tuser[0] func; tdata from_node, to_node, capacity
// m_        out        tdata max_flow; tuser status
// cfg_      in         register writes: node_count, source_node, sink_node
//
// An edge add steps through ADD_RD1, ADD_WR1, ADD_RD2 and ADD_WR2, then the result waits for the output transfer.
// A solve's run time depends on the data and is set by the single read port of
// each arc memory, which serializes the arc visits, the bottleneck and update passes
// over the path arcs, and the pass that resets the current arcs of each node.
// Reset is synchronous; no clearing pass runs after reset.
// The block accepts no item while a result waits for its transfer.
`timescale 1ns / 1ps
module max_flow_isap_engine_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mfi_pkg::S_TDATA_W-1:0]     s_tdata,  // from_node, to_node, capacity
    input  logic [0:0]                        s_tuser,  // func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mfi_pkg::M_TDATA_W-1:0]     m_tdata,  // max_flow
    output logic [mfi_pkg::STAT_W-1:0]        m_tuser,  // status
    input  logic                              cfg_we,
    input  logic [mfi_pkg::CFG_AW-1:0]        cfg_addr,
    input  logic [mfi_pkg::NODE_W-1:0]        cfg_wdata
);
    import mfi_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE, S_ADD_RD1, S_ADD_WR1, S_ADD_RD2, S_ADD_WR2,
        S_LB_INIT, S_LB_POP, S_LB_POP2, S_LB_POP3, S_LB_POP4,
        S_LB_ARC, S_LB_ARC2, S_LB_ARC3, S_SV_CHK0, S_SV_CHK,
        S_CI_RD, S_CI_WR, S_MAIN, S_ADV1, S_SCAN, S_SCAN2, S_SCAN3,
        S_RL1, S_RL2, S_RL3, S_RL4,
        S_AG_MA, S_AG_MB, S_AG_MC, S_AG_UA, S_AG_UB, S_AG_UC, S_AG_UD,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [NODE_W-1:0] node_count_reg, source_reg, sink_reg;
    logic [NODE_W-1:0] from_reg, from_next, to_reg, to_next, n_reg, n_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [ARCP_W-1:0] arc_cnt_reg, arc_cnt_next;
    logic [NODE_W-1:0] qh_reg, qh_next, qt_reg, qt_next;
    logic [LVL_W-1:0]  lv_reg, lv_next, lu_reg, lu_next, src_lvl_reg, src_lvl_next;
    logic [ARCP_W-1:0] a_reg, a_next, link_reg, link_next;
    logic [NODE_W-1:0] q_reg, q_next, u_reg, u_next;
    logic              rnz_reg, rnz_next;
    logic [NODE_W-1:0] depth_reg, depth_next, i_reg, i_next;
    logic [CAP_W-1:0]  b_reg, b_next;
    logic [ARC_W-1:0]  x_reg, x_next;
    logic [FLOW_W-1:0] flow_reg, flow_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_flow_reg, out_flow_next;
    logic [STAT_W-1:0] out_stat_reg, out_stat_next;
    logic [MAX_NODES-1:0] fa_vld_reg, fa_vld_next, lvl_vld_reg, lvl_vld_next;
    logic [POP_D-1:0]  pop_vld_reg, pop_vld_next;
    logic              fa_vq_reg, lvl_vq_reg, pop_vq_reg;

    logic              tgt_we, lnk_we, res_we, fst_we, cur_we, lvl_we, pop_we;
    logic              skn_we, ska_we, que_we;
    logic [ARC_W-1:0]  tgt_wa, lnk_wa, res_wa, tgt_ra, lnk_ra, res_ra;
    logic [NIDX_W-1:0] fst_wa, fst_ra, cur_wa, cur_ra, lvl_wa, lvl_ra;
    logic [NIDX_W-1:0] skn_wa, skn_ra, ska_wa, ska_ra, que_wa, que_ra;
    logic [POP_AW-1:0] pop_wa, pop_ra;
    logic [NODE_W-1:0] tgt_wd, tgt_rd, skn_wd, skn_rd, que_wd, que_rd;
    logic [ARCP_W-1:0] lnk_wd, lnk_rd, fst_wd, fst_rd, cur_wd, cur_rd;
    logic [CAP_W-1:0]  res_wd, res_rd;
    logic [LVL_W-1:0]  lvl_wd, lvl_rd, pop_wd, pop_rd;
    logic [ARC_W-1:0]  ska_wd, ska_rd;

    logic [ARCP_W-1:0] fst_val;
    logic [LVL_W-1:0]  lvl_val, pop_val;
    logic [NODE_W-1:0] n_eff, in_from, in_to;
    logic [CAP_W-1:0]  in_cap;
    logic [ARCP_W-1:0] a_dec;

    assign fst_val = fa_vq_reg ? fst_rd : '0;
    assign lvl_val = lvl_vq_reg ? lvl_rd : '0;
    assign pop_val = pop_vq_reg ? pop_rd : '0;
    assign n_eff   = eff_nodes(node_count_reg);
    assign in_from = s_tdata[NODE_W-1:0];
    assign in_to   = s_tdata[2*NODE_W-1:NODE_W];
    assign in_cap  = s_tdata[2*NODE_W+CAP_W-1:2*NODE_W];
    assign a_dec   = a_reg - ARCP_W'(1);

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, out_flow_reg};
    assign m_tuser  = out_stat_reg;

    mfi_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ARCS)) u_tgt_ram (
        .aclk(aclk), .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd), .raddr(tgt_ra), .rdata(tgt_rd));
    mfi_ram #(.WIDTH(ARCP_W), .DEPTH(MAX_ARCS)) u_lnk_ram (
        .aclk(aclk), .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd), .raddr(lnk_ra), .rdata(lnk_rd));
    mfi_ram #(.WIDTH(CAP_W), .DEPTH(MAX_ARCS)) u_res_ram (
        .aclk(aclk), .we(res_we), .waddr(res_wa), .wdata(res_wd), .raddr(res_ra), .rdata(res_rd));
    mfi_ram #(.WIDTH(ARCP_W), .DEPTH(MAX_NODES)) u_fst_ram (
        .aclk(aclk), .we(fst_we), .waddr(fst_wa), .wdata(fst_wd), .raddr(fst_ra), .rdata(fst_rd));
    mfi_ram #(.WIDTH(ARCP_W), .DEPTH(MAX_NODES)) u_cur_ram (
        .aclk(aclk), .we(cur_we), .waddr(cur_wa), .wdata(cur_wd), .raddr(cur_ra), .rdata(cur_rd));
    mfi_ram #(.WIDTH(LVL_W), .DEPTH(MAX_NODES)) u_lvl_ram (
        .aclk(aclk), .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd), .raddr(lvl_ra), .rdata(lvl_rd));
    mfi_ram #(.WIDTH(LVL_W), .DEPTH(POP_D)) u_pop_ram (
        .aclk(aclk), .we(pop_we), .waddr(pop_wa), .wdata(pop_wd), .raddr(pop_ra), .rdata(pop_rd));
    mfi_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_skn_ram (
        .aclk(aclk), .we(skn_we), .waddr(skn_wa), .wdata(skn_wd), .raddr(skn_ra), .rdata(skn_rd));
    mfi_ram #(.WIDTH(ARC_W), .DEPTH(MAX_NODES)) u_ska_ram (
        .aclk(aclk), .we(ska_we), .waddr(ska_wa), .wdata(ska_wd), .raddr(ska_ra), .rdata(ska_rd));
    mfi_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_que_ram (
        .aclk(aclk), .we(que_we), .waddr(que_wa), .wdata(que_wd), .raddr(que_ra), .rdata(que_rd));

    always_comb begin
        state_next     = state_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        n_next         = n_reg;
        cap_next       = cap_reg;
        arc_cnt_next   = arc_cnt_reg;
        qh_next        = qh_reg;
        qt_next        = qt_reg;
        lv_next        = lv_reg;
        lu_next        = lu_reg;
        src_lvl_next   = src_lvl_reg;
        a_next         = a_reg;
        link_next      = link_reg;
        q_next         = q_reg;
        u_next         = u_reg;
        rnz_next       = rnz_reg;
        depth_next     = depth_reg;
        i_next         = i_reg;
        b_next         = b_reg;
        x_next         = x_reg;
        flow_next      = flow_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_flow_next  = out_flow_reg;
        out_stat_next  = out_stat_reg;
        fa_vld_next    = fa_vld_reg;
        lvl_vld_next   = lvl_vld_reg;
        pop_vld_next   = pop_vld_reg;

        tgt_we = 1'b0; tgt_wa = '0; tgt_wd = '0; tgt_ra = '0;
        lnk_we = 1'b0; lnk_wa = '0; lnk_wd = '0; lnk_ra = '0;
        res_we = 1'b0; res_wa = '0; res_wd = '0; res_ra = '0;
        fst_we = 1'b0; fst_wa = '0; fst_wd = '0; fst_ra = '0;
        cur_we = 1'b0; cur_wa = '0; cur_wd = '0; cur_ra = '0;
        lvl_we = 1'b0; lvl_wa = '0; lvl_wd = '0; lvl_ra = '0;
        pop_we = 1'b0; pop_wa = '0; pop_wd = '0; pop_ra = '0;
        skn_we = 1'b0; skn_wa = '0; skn_wd = '0; skn_ra = '0;
        ska_we = 1'b0; ska_wa = '0; ska_wd = '0; ska_ra = '0;
        que_we = 1'b0; que_wa = '0; que_wd = '0; que_ra = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    from_next = in_from;
                    to_next   = in_to;
                    cap_next  = in_cap;
                    n_next    = n_eff;
                    if (s_tuser[0] == FUNC_ADD) begin
                        if (in_from == '0 || in_from > n_eff || in_to == '0 || in_to > n_eff) begin
                            out_valid_next = 1'b1;
                            out_flow_next  = '0;
                            out_stat_next  = ST_RANGE;
                        end else if (arc_cnt_reg > ARCP_W'(MAX_ARCS - 2)) begin
                            out_valid_next = 1'b1;
                            out_flow_next  = '0;
                            out_stat_next  = ST_FULL;
                        end else begin
                            state_next = S_ADD_RD1;
                        end
                    end else begin
                        flow_next = '0;
                        if (source_reg == '0 || source_reg > n_eff ||
                            sink_reg == '0 || sink_reg > n_eff) begin
                            out_valid_next = 1'b1;
                            out_flow_next  = '0;
                            out_stat_next  = ST_RANGE;
                            arc_cnt_next   = '0;
                            fa_vld_next    = '0;
                        end else if (source_reg == sink_reg) begin
                            out_valid_next = 1'b1;
                            out_flow_next  = '0;
                            out_stat_next  = ST_OK;
                            arc_cnt_next   = '0;
                            fa_vld_next    = '0;
                        end else begin
                            state_next = S_LB_INIT;
                        end
                    end
                end
            end
            S_ADD_RD1: begin
                fst_ra     = node_idx(from_reg);
                state_next = S_ADD_WR1;
            end
            S_ADD_WR1: begin
                tgt_we = 1'b1; tgt_wa = arc_cnt_reg[ARC_W-1:0]; tgt_wd = to_reg;
                res_we = 1'b1; res_wa = arc_cnt_reg[ARC_W-1:0]; res_wd = cap_reg;
                lnk_we = 1'b1; lnk_wa = arc_cnt_reg[ARC_W-1:0]; lnk_wd = fst_val;
                fst_we = 1'b1; fst_wa = node_idx(from_reg);
                fst_wd = arc_cnt_reg + ARCP_W'(1);
                fa_vld_next[node_idx(from_reg)] = 1'b1;
                state_next = S_ADD_RD2;
            end
            S_ADD_RD2: begin
                fst_ra     = node_idx(to_reg);
                state_next = S_ADD_WR2;
            end
            S_ADD_WR2: begin
                tgt_we = 1'b1; tgt_wa = arc_cnt_reg[ARC_W-1:0] | ARC_W'(1); tgt_wd = from_reg;
                res_we = 1'b1; res_wa = arc_cnt_reg[ARC_W-1:0] | ARC_W'(1); res_wd = '0;
                lnk_we = 1'b1; lnk_wa = arc_cnt_reg[ARC_W-1:0] | ARC_W'(1); lnk_wd = fst_val;
                fst_we = 1'b1; fst_wa = node_idx(to_reg);
                fst_wd = arc_cnt_reg + ARCP_W'(2);
                fa_vld_next[node_idx(to_reg)] = 1'b1;
                arc_cnt_next   = arc_cnt_reg + ARCP_W'(2);
                out_valid_next = 1'b1;
                out_flow_next  = '0;
                out_stat_next  = ST_OK;
                state_next     = S_IDLE;
            end
            S_LB_INIT: begin
                lvl_vld_next = '0;
                lvl_vld_next[node_idx(sink_reg)] = 1'b1;
                pop_vld_next = '0;
                lvl_we = 1'b1; lvl_wa = node_idx(sink_reg); lvl_wd = LVL_W'(1);
                que_we = 1'b1; que_wa = '0; que_wd = sink_reg;
                qh_next    = '0;
                qt_next    = NODE_W'(1);
                state_next = S_LB_POP;
            end
            S_LB_POP: begin
                if (qh_reg < qt_reg && qh_reg < n_reg) begin
                    que_ra     = qh_reg[NIDX_W-1:0];
                    qh_next    = qh_reg + NODE_W'(1);
                    state_next = S_LB_POP2;
                end else begin
                    state_next = S_SV_CHK0;
                end
            end
            S_LB_POP2: begin
                lvl_ra     = node_idx(que_rd);
                fst_ra     = node_idx(que_rd);
                state_next = S_LB_POP3;
            end
            S_LB_POP3: begin
                lv_next    = lvl_val;
                a_next     = fst_val;
                pop_ra     = lvl_val;
                state_next = S_LB_POP4;
            end
            S_LB_POP4: begin
                pop_we = 1'b1; pop_wa = lv_reg; pop_wd = pop_val + LVL_W'(1);
                pop_vld_next[lv_reg] = 1'b1;
                state_next = S_LB_ARC;
            end
            S_LB_ARC: begin
                if (a_reg == '0) begin
                    state_next = S_LB_POP;
                end else begin
                    tgt_ra     = a_dec[ARC_W-1:0];
                    lnk_ra     = a_dec[ARC_W-1:0];
                    res_ra     = a_dec[ARC_W-1:0] ^ ARC_W'(1);
                    state_next = S_LB_ARC2;
                end
            end
            S_LB_ARC2: begin
                q_next     = tgt_rd;
                link_next  = lnk_rd;
                rnz_next   = (res_rd != '0);
                lvl_ra     = node_idx(tgt_rd);
                state_next = S_LB_ARC3;
            end
            S_LB_ARC3: begin
                if (q_reg != sink_reg && lvl_val == '0 && rnz_reg && qt_reg < n_reg) begin
                    lvl_we = 1'b1; lvl_wa = node_idx(q_reg); lvl_wd = lv_reg + LVL_W'(1);
                    lvl_vld_next[node_idx(q_reg)] = 1'b1;
                    que_we = 1'b1; que_wa = qt_reg[NIDX_W-1:0]; que_wd = q_reg;
                    qt_next = qt_reg + NODE_W'(1);
                end
                a_next     = link_reg;
                state_next = S_LB_ARC;
            end
            S_SV_CHK0: begin
                lvl_ra     = node_idx(source_reg);
                state_next = S_SV_CHK;
            end
            S_SV_CHK: begin
                if (lvl_val == '0) begin
                    state_next = S_DONE;
                end else begin
                    src_lvl_next = lvl_val;
                    i_next       = '0;
                    state_next   = S_CI_RD;
                end
            end
            S_CI_RD: begin
                if (i_reg < n_reg) begin
                    fst_ra     = i_reg[NIDX_W-1:0];
                    state_next = S_CI_WR;
                end else begin
                    u_next     = source_reg;
                    depth_next = '0;
                    state_next = S_MAIN;
                end
            end
            S_CI_WR: begin
                cur_we = 1'b1; cur_wa = i_reg[NIDX_W-1:0]; cur_wd = fst_val;
                i_next     = i_reg + NODE_W'(1);
                state_next = S_CI_RD;
            end
            S_MAIN: begin
                if (src_lvl_reg > n_reg) begin
                    state_next = S_DONE;
                end else if (u_reg == sink_reg) begin
                    i_next     = '0;
                    b_next     = INF_LIMIT;
                    state_next = S_AG_MA;
                end else begin
                    cur_ra     = node_idx(u_reg);
                    lvl_ra     = node_idx(u_reg);
                    state_next = S_ADV1;
                end
            end
            S_ADV1: begin
                a_next     = cur_rd;
                lu_next    = lvl_val;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (a_reg == '0) begin
                    state_next = S_RL1;
                end else begin
                    tgt_ra     = a_dec[ARC_W-1:0];
                    lnk_ra     = a_dec[ARC_W-1:0];
                    res_ra     = a_dec[ARC_W-1:0];
                    state_next = S_SCAN2;
                end
            end
            S_SCAN2: begin
                q_next     = tgt_rd;
                link_next  = lnk_rd;
                rnz_next   = (res_rd != '0);
                lvl_ra     = node_idx(tgt_rd);
                state_next = S_SCAN3;
            end
            S_SCAN3: begin
                if (rnz_reg && (lvl_val + LVL_W'(1)) == lu_reg) begin
                    if (depth_reg < NODE_W'(MAX_NODES)) begin
                        cur_we = 1'b1; cur_wa = node_idx(u_reg); cur_wd = a_reg;
                        skn_we = 1'b1; skn_wa = depth_reg[NIDX_W-1:0]; skn_wd = u_reg;
                        ska_we = 1'b1; ska_wa = depth_reg[NIDX_W-1:0];
                        ska_wd = a_dec[ARC_W-1:0];
                        depth_next = depth_reg + NODE_W'(1);
                        u_next     = q_reg;
                        state_next = S_MAIN;
                    end else begin
                        state_next = S_RL1;
                    end
                end else begin
                    a_next     = link_reg;
                    state_next = S_SCAN;
                end
            end
            S_RL1: begin
                pop_ra     = lu_reg;
                state_next = S_RL2;
            end
            S_RL2: begin
                if (pop_val == LVL_W'(1)) begin
                    state_next = S_DONE;
                end else begin
                    pop_we = 1'b1; pop_wa = lu_reg; pop_wd = pop_val - LVL_W'(1);
                    pop_vld_next[lu_reg] = 1'b1;
                    lvl_we = 1'b1; lvl_wa = node_idx(u_reg); lvl_wd = lu_reg + LVL_W'(1);
                    if (u_reg == source_reg) begin
                        src_lvl_next = lu_reg + LVL_W'(1);
                    end
                    pop_ra     = lu_reg + LVL_W'(1);
                    fst_ra     = node_idx(u_reg);
                    state_next = S_RL3;
                end
            end
            S_RL3: begin
                pop_we = 1'b1; pop_wa = lu_reg + LVL_W'(1); pop_wd = pop_val + LVL_W'(1);
                pop_vld_next[lu_reg + LVL_W'(1)] = 1'b1;
                cur_we = 1'b1; cur_wa = node_idx(u_reg); cur_wd = fst_val;
                if (u_reg != source_reg && depth_reg != '0) begin
                    depth_next = depth_reg - NODE_W'(1);
                    skn_ra     = node_idx(depth_reg);
                    state_next = S_RL4;
                end else begin
                    state_next = S_MAIN;
                end
            end
            S_RL4: begin
                u_next     = skn_rd;
                state_next = S_MAIN;
            end
            S_AG_MA: begin
                if (i_reg < depth_reg) begin
                    ska_ra     = i_reg[NIDX_W-1:0];
                    state_next = S_AG_MB;
                end else begin
                    i_next     = '0;
                    state_next = S_AG_UA;
                end
            end
            S_AG_MB: begin
                res_ra     = ska_rd;
                state_next = S_AG_MC;
            end
            S_AG_MC: begin
                if (res_rd < b_reg) begin
                    b_next = res_rd;
                end
                i_next     = i_reg + NODE_W'(1);
                state_next = S_AG_MA;
            end
            S_AG_UA: begin
                if (i_reg < depth_reg) begin
                    ska_ra     = i_reg[NIDX_W-1:0];
                    state_next = S_AG_UB;
                end else begin
                    flow_next  = flow_reg + FLOW_W'(b_reg);
                    u_next     = source_reg;
                    depth_next = '0;
                    state_next = S_MAIN;
                end
            end
            S_AG_UB: begin
                x_next     = ska_rd;
                res_ra     = ska_rd;
                state_next = S_AG_UC;
            end
            S_AG_UC: begin
                res_we = 1'b1; res_wa = x_reg; res_wd = res_rd - b_reg;
                res_ra     = x_reg ^ ARC_W'(1);
                state_next = S_AG_UD;
            end
            S_AG_UD: begin
                res_we = 1'b1; res_wa = x_reg ^ ARC_W'(1); res_wd = res_rd + b_reg;
                i_next     = i_reg + NODE_W'(1);
                state_next = S_AG_UA;
            end
            S_DONE: begin
                out_valid_next = 1'b1;
                out_flow_next  = flow_reg[FLOW_W-1] ? {OUT_W{1'b1}} : flow_reg[OUT_W-1:0];
                out_stat_next  = ST_OK;
                arc_cnt_next   = '0;
                fa_vld_next    = '0;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            node_count_reg <= NODE_W'(2);
            source_reg     <= NODE_W'(1);
            sink_reg       <= NODE_W'(2);
            arc_cnt_reg    <= '0;
            flow_reg       <= '0;
            out_valid_reg  <= 1'b0;
            fa_vld_reg     <= '0;
            lvl_vld_reg    <= '0;
            pop_vld_reg    <= '0;
            depth_reg      <= '0;
            qt_reg         <= '0;
            src_lvl_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            arc_cnt_reg   <= arc_cnt_next;
            flow_reg      <= flow_next;
            out_valid_reg <= out_valid_next;
            fa_vld_reg    <= fa_vld_next;
            lvl_vld_reg   <= lvl_vld_next;
            pop_vld_reg   <= pop_vld_next;
            depth_reg     <= depth_next;
            qt_reg        <= qt_next;
            src_lvl_reg   <= src_lvl_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_NODES:  node_count_reg <= cfg_wdata;
                    CFG_SOURCE: source_reg     <= cfg_wdata;
                    CFG_SINK:   sink_reg       <= cfg_wdata;
                    default:    ;
                endcase
            end
        end
        from_reg     <= from_next;
        to_reg       <= to_next;
        n_reg        <= n_next;
        cap_reg      <= cap_next;
        qh_reg       <= qh_next;
        lv_reg       <= lv_next;
        lu_reg       <= lu_next;
        a_reg        <= a_next;
        link_reg     <= link_next;
        q_reg        <= q_next;
        u_reg        <= u_next;
        rnz_reg      <= rnz_next;
        i_reg        <= i_next;
        b_reg        <= b_next;
        x_reg        <= x_next;
        out_flow_reg <= out_flow_next;
        out_stat_reg <= out_stat_next;
        fa_vq_reg    <= fa_vld_reg[fst_ra];
        lvl_vq_reg   <= lvl_vld_reg[lvl_ra];
        pop_vq_reg   <= pop_vld_reg[pop_ra];
    end

    // The arc store always holds whole edge pairs and never overruns.
    a_arc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        arc_cnt_reg[0] == 1'b0 && arc_cnt_reg <= ARCP_W'(MAX_ARCS))
        else $error("arc count is odd or past the store size");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= NODE_W'(MAX_NODES))
        else $error("walk stack overran");

    a_src_level: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MAIN |-> src_lvl_reg != '0)
        else $error("walk running with an unlabeled source");

    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> out_valid_reg && $stable(out_flow_reg)
        && $stable(out_stat_reg))
        else $error("pending result changed before its transfer");

endmodule
